>>> design/lcgfp_pkg.sv
`default_nettype none

package lcgfp_pkg;

	// widths of the request fields and of the sequence value
	localparam int MOD_W   = 8;
	localparam int COEF_W  = 7;
	localparam int VAL_W   = 8;

	// a*d + c fits in 16 bits; the remainder unit retires DIV_BITS bits per cycle
	localparam int PROD_W    = 16;
	localparam int DIV_BITS  = 4;
	localparam int DIV_STEPS = PROD_W / DIV_BITS;
	localparam int DIVC_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_MUL,
		ST_DIV,
		ST_READ,
		ST_CHECK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;       // capture request fields
		logic clr_wr;     // clearing pass write at the clear counter
		logic step_init;  // d = 0, step = 1
		logic div_start;  // load a*d + c into the remainder unit
		logic div_step;   // one digit of the remainder
		logic rd;         // read bitmap at the new value
		logic chk;        // mark new value, advance d and step
		logic out_load;   // load result register
		logic out_value;
	} cmd_t;

	typedef struct packed {
		logic m_over;     // modulus above the bitmap depth
		logic m_small;    // modulus of zero or one
		logic clr_last;
		logic step_last;
		logic seen;
	} sts_t;

endpackage

`default_nettype wire

>>> design/lcgfp_modred.sv
`default_nettype none

module lcgfp_modred import lcgfp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              start,
	input  wire logic              step,
	input  wire logic [PROD_W-1:0] dividend,
	input  wire logic [VAL_W-1:0]  divisor,
	output logic      [VAL_W-1:0]  rem
);

	logic [PROD_W-1:0] num_q;
	logic [VAL_W-1:0]  rem_q;
	logic [VAL_W-1:0]  rem_d;

	// restoring remainder, MSB first; rem_q stays below divisor so one subtract per bit
	always_comb begin
		logic [VAL_W:0] t;
		rem_d = rem_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			t = {rem_d, num_q[PROD_W-1-i]};
			if (t >= {1'b0, divisor}) begin
				t = t - {1'b0, divisor};
			end
			rem_d = t[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (step) begin
			num_q <= num_q << DIV_BITS;
			rem_q <= rem_d;
		end
	end

	assign rem = rem_q;

endmodule

`default_nettype wire

>>> design/lcgfp_dp.sv
`default_nettype none

module lcgfp_dp import lcgfp_pkg::*; #(
	parameter int MAX_MODULUS = 128
) (
	input  wire logic              clk,
	input  wire logic [MOD_W-1:0]  modulus,
	input  wire logic [COEF_W-1:0] multiplier,
	input  wire logic [COEF_W-1:0] increment,
	input  wire cmd_t              cmd,
	output sts_t                   sts,
	output logic                   full_period
);

	localparam int AW = $clog2(MAX_MODULUS);

	logic [MOD_W-1:0]  m_q;
	logic [COEF_W-1:0] a_q;
	logic [COEF_W-1:0] c_q;
	logic [VAL_W-1:0]  d_q;
	logic [VAL_W-1:0]  cnt_q;
	logic [VAL_W-1:0]  step_q;
	logic              rd_bit_q;
	logic              full_period_q;

	logic [PROD_W-1:0] prod;
	logic [VAL_W-1:0]  rem;

	logic seen_mem [MAX_MODULUS];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_q   <= modulus;
			a_q   <= multiplier;
			c_q   <= increment;
			cnt_q <= '0;
		end else if (cmd.clr_wr) begin
			cnt_q <= cnt_q + VAL_W'(1);
		end
		if (cmd.step_init) begin
			d_q    <= '0;
			step_q <= VAL_W'(1);
		end else if (cmd.chk) begin
			d_q    <= rem;
			step_q <= step_q + VAL_W'(1);
		end
		if (cmd.out_load) begin
			full_period_q <= cmd.out_value;
		end
	end

	assign prod = PROD_W'(a_q) * PROD_W'(d_q) + PROD_W'(c_q);

	lcgfp_modred u_modred (
		.clk      (clk),
		.start    (cmd.div_start),
		.step     (cmd.div_step),
		.dividend (prod),
		.divisor  (m_q),
		.rem      (rem)
	);

	// only entries below the modulus are ever touched; the clearing pass marks 0 as seen
	always_ff @(posedge clk) begin
		if (cmd.clr_wr) begin
			seen_mem[AW'(cnt_q)] <= (cnt_q == '0);
		end else if (cmd.chk) begin
			seen_mem[AW'(rem)] <= 1'b1;
		end
		if (cmd.rd) begin
			rd_bit_q <= seen_mem[AW'(rem)];
		end
	end

	always_comb begin
		sts.m_over    = 32'(modulus) > 32'(MAX_MODULUS);
		sts.m_small   = modulus <= MOD_W'(1);
		sts.clr_last  = cnt_q == (m_q - VAL_W'(1));
		sts.step_last = step_q == (m_q - VAL_W'(1));
		sts.seen      = rd_bit_q;
	end

	assign full_period = full_period_q;

endmodule

`default_nettype wire

>>> design/lcgfp_ctrl.sv
`default_nettype none

module lcgfp_ctrl import lcgfp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  wire logic out_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t            state_q, state_d;
	logic [DIVC_W-1:0] div_cnt_q, div_cnt_d;
	logic              ok_q, ok_d;
	logic              out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_cnt_q   <= '0;
			ok_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			div_cnt_q <= div_cnt_d;
			ok_q      <= ok_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		div_cnt_d = div_cnt_q;
		ok_d      = ok_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (sts.m_over) begin
						ok_d    = 1'b0;
						state_d = ST_DONE;
					end else if (sts.m_small) begin
						ok_d    = 1'b1;
						state_d = ST_DONE;
					end else begin
						state_d = ST_CLEAR;
					end
				end
			end
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					cmd.step_init = 1'b1;
					state_d       = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.div_start = 1'b1;
				div_cnt_d     = '0;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				div_cnt_d    = div_cnt_q + DIVC_W'(1);
				if (div_cnt_q == DIVC_W'(DIV_STEPS - 1)) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.chk = 1'b1;
				if (sts.seen) begin
					ok_d    = 1'b0;
					state_d = ST_DONE;
				end else if (sts.step_last) begin
					ok_d    = 1'b1;
					state_d = ST_DONE;
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_DONE: begin
				// wait here only while the previous result is still held
				if (!out_valid_q || !out_stall) begin
					cmd.out_load  = 1'b1;
					cmd.out_value = ok_q;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

>>> design/lcg_full_period_check_top.sv
// Full-period check of the sequence d = (a*d + c) mod M started at 0: full_period is 1
// when M-1 steps give no repeated value, 0 at the first repeat, and 0 when M exceeds
// MAX_MODULUS; M of 0 or 1 answers 1. One request is in work at a time, and a new one is
// taken while the previous result still waits at the output. For 2 <= M <= MAX_MODULUS a
// check first clears the bitmap (entries 0..M-1), then runs up to M-1 steps, each a
// multiply-add, the 4-bit-per-cycle remainder unit, a registered bitmap read, and check
// and mark; it stops early at the first repeat. It then loads the result, which can wait
// while the previous result is still held at the output. Other moduli skip straight to
// loading the result.
`default_nettype none

module lcg_full_period_check_top import lcgfp_pkg::*; #(
	parameter int MAX_MODULUS = 128
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [MOD_W-1:0]  modulus,
	input  wire logic [COEF_W-1:0] multiplier,
	input  wire logic [COEF_W-1:0] increment,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   full_period
);

	cmd_t cmd;
	sts_t sts;

	lcgfp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	lcgfp_dp #(
		.MAX_MODULUS (MAX_MODULUS)
	) u_dp (
		.clk         (clk),
		.modulus     (modulus),
		.multiplier  (multiplier),
		.increment   (increment),
		.cmd         (cmd),
		.sts         (sts),
		.full_period (full_period)
	);

endmodule

`default_nettype wire

>>> design/lcgfp_chk.sv
`default_nettype none

module lcgfp_chk import lcgfp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic full_period
);

	logic       in_xfer;
	logic       out_xfer;
	logic [1:0] pend_q;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;

	// requests taken whose result has not yet been transferred out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_xfer) - 2'(out_xfer);
		end
	end

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> in_stall)
		else $error("block not busy after request transfer");

	a_no_orphan_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result shown with no request outstanding");

	a_two_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two requests outstanding");

	a_idle_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_stall) |-> out_valid)
		else $error("check finished without a result posted");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(full_period))
		else $error("stalled result changed");

endmodule

bind lcg_full_period_check_top lcgfp_chk u_chk (.*);

`default_nettype wire
